>>> hw/rtl/varint_zigzag_encoder_defines.svh
// Assertion macros shared by the varint zigzag encoder RTL.
`ifndef VARINT_ZIGZAG_ENCODER_DEFINES_SVH
`define VARINT_ZIGZAG_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VZE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("varint encoder check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define VZE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("varint encoder check failed: next-cycle implication");

`endif

>>> hw/rtl/vze_pkg.sv
// Constants and types shared by the varint zigzag encoder modules.
package vze_pkg;

  localparam int VALUE_W    = 64;
  localparam int GROUP_BITS = 7;
  localparam int MAX_BYTES  = 10;
  localparam int ALIGN_W    = GROUP_BITS * MAX_BYTES;
  localparam int LEN_W      = 4;
  localparam int BYTE_W     = 8;

  // Mapped value, left aligned so its top group sits at the MSB, plus its byte count.
  typedef struct packed {
    logic [ALIGN_W-1:0] data;
    logic [LEN_W-1:0]   len;
  } vze_prep_t;

endpackage

>>> hw/rtl/varint_zigzag_encoder.sv
// Top level of the varint zigzag encoder.
// Each accepted 64-bit value (optionally zigzag mapped when in_mode is 1) leaves as
// 1 to 10 words on the result channel, most significant 7-bit group first, one word
// per cycle while out_stall is low; every word carries the encoding's length and
// the final word has out_last set. Each word passes through the work register and
// then the single output register. The next value is accepted in the same cycle
// that the current value's last word moves into the output register, so there is
// no gap between encodings while the result side does not stall.
`include "varint_zigzag_encoder_defines.svh"

module varint_zigzag_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [vze_pkg::VALUE_W-1:0]     in_value,
  input  logic                            in_mode,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [vze_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last,
  output logic [vze_pkg::LEN_W-1:0]       out_enc_length
);

  vze_pkg::vze_prep_t           prep;
  logic                         work_vld_r;
  logic [vze_pkg::ALIGN_W-1:0]  work_data_r;
  logic [vze_pkg::LEN_W-1:0]    work_len_r;
  logic [vze_pkg::LEN_W-1:0]    work_rem_r;
  logic                         out_vld_r;
  logic [vze_pkg::BYTE_W-1:0]   out_byte_r;
  logic                         out_last_r;
  logic [vze_pkg::LEN_W-1:0]    out_len_r;
  logic                         out_load;
  logic                         work_done;
  logic                         in_acc;
  logic                         is_final;

  vze_prep u_prep (
    .value (in_value),
    .mode  (in_mode),
    .prep  (prep)
  );

  assign is_final  = (work_rem_r == vze_pkg::LEN_W'(1));
  assign out_load  = work_vld_r && (!out_vld_r || !out_stall);
  assign work_done = out_load && is_final;
  assign in_stall  = work_vld_r && !work_done;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
      work_rem_r <= '0;
    end else if (in_acc) begin
      work_vld_r <= 1'b1;
      work_rem_r <= prep.len;
    end else if (out_load) begin
      work_vld_r <= !is_final;
      work_rem_r <= vze_pkg::LEN_W'(work_rem_r - vze_pkg::LEN_W'(1));
    end
  end

  // Payload of the work register: the top group is always the next word to send.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      work_data_r <= prep.data;
      work_len_r  <= prep.len;
    end else if (out_load) begin
      work_data_r <= work_data_r << vze_pkg::GROUP_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= {!is_final,
                     work_data_r[vze_pkg::ALIGN_W-1 -: vze_pkg::GROUP_BITS]};
      out_last_r <= is_final;
      out_len_r  <= work_len_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_byte       = out_byte_r;
  assign out_last       = out_last_r;
  assign out_enc_length = out_len_r;

  `VZE_ASSERT_IMP(a_rem_in_range, work_vld_r, (work_rem_r != '0) && (work_rem_r <= work_len_r))
  `VZE_ASSERT_NXT(a_done_gives_last, work_done, out_vld_r && out_last_r)
  `VZE_ASSERT_NXT(a_load_full_count, in_acc, work_vld_r && (work_rem_r == work_len_r))

endmodule

>>> hw/rtl/vze_prep.sv
// Zigzag mapping, length detection and group alignment of one input value.
module vze_prep (
  input  logic [vze_pkg::VALUE_W-1:0] value,
  input  logic                        mode,
  output vze_pkg::vze_prep_t          prep
);

  logic [vze_pkg::VALUE_W-1:0] mapped;
  logic [vze_pkg::ALIGN_W-1:0] wide;
  logic [vze_pkg::LEN_W-1:0]   len;

  // Zigzag: shift left and flip every bit when the value is negative.
  assign mapped = mode ? ((value << 1) ^ {vze_pkg::VALUE_W{value[vze_pkg::VALUE_W-1]}})
                       : value;

  assign wide = vze_pkg::ALIGN_W'(mapped);

  always_comb begin
    len = vze_pkg::LEN_W'(1);
    for (int k = 1; k < vze_pkg::MAX_BYTES; k++) begin
      if ((wide >> (vze_pkg::GROUP_BITS * k)) != '0) begin
        len = vze_pkg::LEN_W'(k + 1);
      end
    end
  end

  always_comb begin
    prep.len  = len;
    prep.data = wide;
    for (int k = 1; k <= vze_pkg::MAX_BYTES; k++) begin
      if (len == vze_pkg::LEN_W'(k)) begin
        prep.data = wide << (vze_pkg::GROUP_BITS * (vze_pkg::MAX_BYTES - k));
      end
    end
  end

endmodule

>>> verif/tb_varint_zigzag_encoder.sv
// Self-checking testbench for the varint zigzag encoder: directed table plus random values.
`timescale 1ns / 100ps

module tb_varint_zigzag_encoder;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_ZIGZAG   = 1'b1;
  localparam int   IDLE_PCT      = 29;
  localparam int   RANDOM_ITEMS  = 160;

  typedef struct {
    logic [vze_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic [vze_pkg::LEN_W-1:0]  len;
  } enc_word_t;

  // A length of zero means the row is checked against the encoder model only.
  typedef struct {
    logic [vze_pkg::VALUE_W-1:0]                  value;
    logic                                         mode;
    logic [vze_pkg::LEN_W-1:0]                    n;
    logic [vze_pkg::BYTE_W*vze_pkg::MAX_BYTES-1:0] bytes;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [vze_pkg::VALUE_W-1:0]  in_value;
  logic                         in_mode;
  logic                         out_valid;
  logic                         out_stall;
  logic [vze_pkg::BYTE_W-1:0]   out_byte;
  logic                         out_last;
  logic [vze_pkg::LEN_W-1:0]    out_enc_length;

  enc_word_t pending_words[$];
  dir_row_t  dir_rows[$];
  int        err_count;
  int        idle_pct;

  varint_zigzag_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_enc_length (out_enc_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Queues the words that one value is expected to produce.
  function automatic void encode_varint(input logic [vze_pkg::VALUE_W-1:0] raw,
                                        input logic mode);
    logic [vze_pkg::VALUE_W-1:0] mapped;
    int                          n;
    int                          shift;
    enc_word_t                   w;
    mapped = (mode == MODE_ZIGZAG) ?
             ((raw << 1) ^ {vze_pkg::VALUE_W{raw[vze_pkg::VALUE_W-1]}}) : raw;
    n = 1;
    while (n < vze_pkg::MAX_BYTES && (mapped >> (vze_pkg::GROUP_BITS * n)) != 0) n++;
    for (int k = 0; k < n; k++) begin
      shift = vze_pkg::GROUP_BITS * (n - 1 - k);
      w.data = vze_pkg::BYTE_W'((mapped >> shift) & 64'h7f);
      w.last = (k == n - 1);
      if (!w.last) w.data[7] = 1'b1;
      w.len = vze_pkg::LEN_W'(n);
      pending_words.push_back(w);
    end
  endfunction

  function automatic void queue_typed(input dir_row_t row);
    enc_word_t w;
    for (int k = 0; k < row.n; k++) begin
      w.data = row.bytes[vze_pkg::BYTE_W*vze_pkg::MAX_BYTES-1-vze_pkg::BYTE_W*k
                         -: vze_pkg::BYTE_W];
      w.last = (k == row.n - 1);
      w.len  = row.n;
      pending_words.push_back(w);
    end
  endfunction

  // Leaves valid high after acceptance so back-to-back values need no extra edge.
  task automatic drive_value(input logic [vze_pkg::VALUE_W-1:0] v, input logic m);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_mode  <= m;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [vze_pkg::VALUE_W-1:0] random_value(input logic m);
    logic [vze_pkg::VALUE_W-1:0] v;
    int                          bits;
    bits = $urandom_range(1, vze_pkg::VALUE_W);
    v = {$urandom(), $urandom()};
    if (bits < vze_pkg::VALUE_W) v = v & ((64'd1 << bits) - 1);
    if ($urandom_range(0, 1) == 1) v[bits-1] = 1'b1;
    if (m == MODE_ZIGZAG && $urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: word with none expected: byte %h last %b len %0d",
                 $time, out_byte, out_last, out_enc_length);
        err_count++;
      end else begin
        enc_word_t w;
        w = pending_words.pop_front();
        if (out_byte !== w.data) begin
          $display("%0t: byte mismatch: expected %h, got %h", $time, w.data, out_byte);
          err_count++;
        end
        if (out_last !== w.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, w.last, out_last);
          err_count++;
        end
        if (out_enc_length !== w.len) begin
          $display("%0t: length mismatch: expected %0d, got %0d",
                   $time, w.len, out_enc_length);
          err_count++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  initial begin
    logic [vze_pkg::VALUE_W-1:0] v;
    logic                        m;
    err_count = 0;
    idle_pct  = IDLE_PCT;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_value  <= '0;
    in_mode   <= MODE_UNSIGNED;

    dir_rows.push_back('{64'h0, MODE_UNSIGNED, 4'd1, {8'h00, 72'h0}});
    dir_rows.push_back('{64'h0, MODE_ZIGZAG, 4'd1, {8'h00, 72'h0}});
    dir_rows.push_back('{64'h1, MODE_UNSIGNED, 4'd1, {8'h01, 72'h0}});
    dir_rows.push_back('{64'h7f, MODE_UNSIGNED, 4'd1, {8'h7f, 72'h0}});
    dir_rows.push_back('{64'h80, MODE_UNSIGNED, 4'd2, {8'h81, 8'h00, 64'h0}});
    dir_rows.push_back('{64'hffff_ffff_ffff_ffff, MODE_UNSIGNED, 4'd10,
                         {8'h81, {8{8'hff}}, 8'h7f}});
    dir_rows.push_back('{64'h8000_0000_0000_0000, MODE_UNSIGNED, 4'd10,
                         {8'h81, {8{8'h80}}, 8'h00}});
    // The most negative value maps to all ones under zigzag.
    dir_rows.push_back('{64'h8000_0000_0000_0000, MODE_ZIGZAG, 4'd10,
                         {8'h81, {8{8'hff}}, 8'h7f}});
    dir_rows.push_back('{64'hffff_ffff_ffff_ffff, MODE_ZIGZAG, 4'd1, {8'h01, 72'h0}});
    dir_rows.push_back('{64'h7fff_ffff_ffff_ffff, MODE_ZIGZAG, 4'd10,
                         {8'h81, {8{8'hff}}, 8'h7e}});
    dir_rows.push_back('{64'h1, MODE_ZIGZAG, 4'd1, {8'h02, 72'h0}});
    dir_rows.push_back('{64'd63, MODE_ZIGZAG, 4'd0, '0});
    dir_rows.push_back('{-64'd64, MODE_ZIGZAG, 4'd0, '0});
    dir_rows.push_back('{-64'd65, MODE_ZIGZAG, 4'd0, '0});
    dir_rows.push_back('{64'd16383, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'd16384, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'h00ff_ffff_ffff_ffff, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'h0100_0000_0000_0000, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'h7fff_ffff_ffff_ffff, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'h5555_5555_5555_5555, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'haaaa_aaaa_aaaa_aaaa, MODE_ZIGZAG, 4'd0, '0});
    dir_rows.push_back('{64'h0000_0008_0000_0000, MODE_UNSIGNED, 4'd0, '0});
    dir_rows.push_back('{64'haaaa_aaaa_aaaa_aaaa, MODE_UNSIGNED, 4'd0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      drive_value(dir_rows[i].value, dir_rows[i].mode);
      if (dir_rows[i].n != 0) queue_typed(dir_rows[i]);
      else encode_varint(dir_rows[i].value, dir_rows[i].mode);
    end
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // A stretch of full-rate traffic on both sides.
      idle_pct = (i >= 60 && i < 100) ? 0 : IDLE_PCT;
      if (i == 130) wait_drained();
      m = $urandom_range(0, 1) ? MODE_ZIGZAG : MODE_UNSIGNED;
      v = random_value(m);
      drive_value(v, m);
      encode_varint(v, m);
    end
    wait_drained();
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
